FILE: sv/nmu_pkg.sv
// nmu_pkg: shared types and constants for the neighbour majority update core.
// Used by neighbor_majority_update_core, nmu_vote and nmu_checker.
// No dependencies.
`default_nettype none
package nmu_pkg;

  localparam int unsigned STATE_W = 5;   // width of a cell state
  localparam int unsigned VOTE_W  = 4;   // width of a vote count (0..8)
  localparam int unsigned COORD_W = 8;   // width of the row and column ports
  localparam int unsigned COORD_XW = 11; // wide enough to hold the largest grid side
  localparam int unsigned NUM_NBR = 8;   // Moore neighbourhood size

  // Command codes; the unused code behaves as a read
  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_READ   = 2'd2
  } nmu_cmd_e;

  // Sequencer states of the top level
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_NBR,
    ST_VOTE,
    ST_RESP
  } nmu_fsm_e;

  // Neighbour slot order: NW, N, NE, W, E, SW, S, SE (bit i is slot i)
  localparam logic [NUM_NBR-1:0] ROW_DEC = 8'b0000_0111;
  localparam logic [NUM_NBR-1:0] ROW_INC = 8'b1110_0000;
  localparam logic [NUM_NBR-1:0] COL_DEC = 8'b0010_1001;
  localparam logic [NUM_NBR-1:0] COL_INC = 8'b1001_0100;

  // One gathered neighbour: vld set when it lies in the grid and casts a vote
  typedef struct packed {
    logic               vld;
    logic [STATE_W-1:0] st;
  } nmu_nbr_t;

  // Outcome of the vote unit
  typedef struct packed {
    logic               done;
    logic [STATE_W-1:0] best_st;
    logic [VOTE_W-1:0]  best_n;
  } nmu_vote_t;

endpackage : nmu_pkg
`default_nettype wire

FILE: sv/nmu_vote.sv
// nmu_vote: two-stage majority vote over the eight gathered neighbours.
// Stage one counts matches per neighbour, stage two picks the winner.
// Depends on nmu_pkg.
`default_nettype none
module nmu_vote
  import nmu_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire nmu_nbr_t nbr_i [NUM_NBR],
  output nmu_vote_t     res_o
);

  logic [VOTE_W-1:0]  cnt_q [NUM_NBR];
  logic [VOTE_W-1:0]  cnt_d [NUM_NBR];
  logic [STATE_W-1:0] st_q  [NUM_NBR];
  logic               cnt_vld_q;
  logic               done_q;
  logic [STATE_W-1:0] best_st_q, best_st_d;
  logic [VOTE_W-1:0]  best_n_q, best_n_d;

  // Stage one: how many voting neighbours share each neighbour's state
  always_comb begin
    for (int i = 0; i < NUM_NBR; i++) begin
      cnt_d[i] = '0;
      for (int j = 0; j < NUM_NBR; j++) begin
        if (nbr_i[i].vld && nbr_i[j].vld && (nbr_i[i].st == nbr_i[j].st)) begin
          cnt_d[i] = cnt_d[i] + VOTE_W'(1);
        end
      end
    end
  end

  // Stage two: highest count wins, lowest state breaks a tie; no votes gives state 1
  always_comb begin
    best_st_d = STATE_W'(1);
    best_n_d  = '0;
    for (int i = 0; i < NUM_NBR; i++) begin
      if ((cnt_q[i] > best_n_d) ||
          ((cnt_q[i] == best_n_d) && (cnt_q[i] != '0) && (st_q[i] < best_st_d))) begin
        best_n_d  = cnt_q[i];
        best_st_d = st_q[i];
      end
    end
  end

  // Stage data, no reset needed
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int i = 0; i < NUM_NBR; i++) begin
        cnt_q[i] <= cnt_d[i];
        st_q[i]  <= nbr_i[i].st;
      end
    end
    if (cnt_vld_q) begin
      best_st_q <= best_st_d;
      best_n_q  <= best_n_d;
    end
  end

  // Stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      cnt_vld_q <= start_i;
      done_q    <= cnt_vld_q;
    end
  end

  assign res_o.done    = done_q;
  assign res_o.best_st = best_st_q;
  assign res_o.best_n  = best_n_q;

endmodule : nmu_vote
`default_nettype wire

FILE: sv/neighbor_majority_update_core.sv
// neighbor_majority_update_core: grid of cell states with write, read and
// Moore-neighbourhood majority update. Depends on nmu_pkg and nmu_vote.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one word: cmd, row, col,
//   state_value. Output channel (out_valid_o / out_ready_i) returns one word
//   per input: cell_state and winner_votes.
//   The grid sits in one single-port synchronous RAM (one access a cycle,
//   read data in the next cycle). Words are worked one at a time.
//   A write passes a decode step and then the response step; a read waits
//   for the RAM data between them; an update runs a decode step, then the
//   neighbour phase (eight reads through the RAM port, then catching the
//   last word and starting the vote), the vote unit and the write-back of
//   the winner, then the response step; a coordinate outside the grid goes
//   straight to the response step. The next word is accepted once the
//   result is loaded into the output register, so a new word never starts
//   before the result of the last one is in the output register.
//   If the receiver stalls, the result waits in the output register; the
//   core may take and work the next word, and holds its result until the
//   output register frees up.
//   Reset clears the control state only; grid contents are undefined until
//   written, and no clearing pass runs.
`default_nettype none
module neighbor_majority_update_core
  import nmu_pkg::*;
#(
  parameter int unsigned GRID_SIDE  = 256,
  parameter int unsigned NUM_STATES = 20
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         cmd_i,
  input  wire logic [COORD_W-1:0] row_i,
  input  wire logic [COORD_W-1:0] col_i,
  input  wire logic [STATE_W-1:0] state_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [STATE_W-1:0]      cell_state_o,
  output logic [VOTE_W-1:0]       winner_votes_o
);

  localparam int unsigned CW    = $clog2(GRID_SIDE);
  localparam int unsigned AW    = 2 * CW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam logic [COORD_XW-1:0] SIDE_X = COORD_XW'(GRID_SIDE);
  localparam logic [CW-1:0]       LAST_IDX = CW'(GRID_SIDE - 1);
  localparam logic [STATE_W-1:0]  MAX_ST  = STATE_W'(NUM_STATES);

  nmu_fsm_e           state_q, state_d;
  logic [1:0]         cmd_q, cmd_d;
  logic [CW-1:0]      row_q, row_d, col_q, col_d;
  logic [STATE_W-1:0] sv_q, sv_d;
  logic [STATE_W-1:0] resp_st_q, resp_st_d;
  logic [VOTE_W-1:0]  resp_n_q, resp_n_d;
  logic [3:0]         slot_q, slot_d;
  logic               issue_ok_q, issue_ok_d;
  logic               out_valid_q, out_valid_d;
  logic [STATE_W-1:0] out_st_q, out_st_d;
  logic [VOTE_W-1:0]  out_n_q, out_n_d;

  nmu_nbr_t nbr_q [NUM_NBR];
  nmu_nbr_t cap_val;
  logic     cap_we;
  logic [2:0] cap_idx;

  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [STATE_W-1:0] mem_wdata;
  logic [STATE_W-1:0] mem_rdata_q;
  logic [STATE_W-1:0] grid_mem [DEPTH];

  logic [COORD_XW-1:0] row_x, col_x;
  logic                in_grid;
  logic [STATE_W-1:0]  sv_clamp;
  logic [2:0]          slot_idx;
  logic [CW-1:0]       nr, nc;
  logic                slot_ok;
  logic                vote_start;
  nmu_vote_t           vote_res;

  // Input coordinate check against the grid side
  assign row_x   = {{(COORD_XW-COORD_W){1'b0}}, row_i};
  assign col_x   = {{(COORD_XW-COORD_W){1'b0}}, col_i};
  assign in_grid = (row_x < SIDE_X) && (col_x < SIDE_X);

  // Written state forced into 1..NUM_STATES
  assign sv_clamp = (sv_q == '0) ? STATE_W'(1) : ((sv_q > MAX_ST) ? MAX_ST : sv_q);

  // Neighbour coordinate and in-grid flag for the slot being issued
  assign slot_idx = slot_q[2:0];
  assign nr = ROW_DEC[slot_idx] ? row_q - CW'(1) :
              (ROW_INC[slot_idx] ? row_q + CW'(1) : row_q);
  assign nc = COL_DEC[slot_idx] ? col_q - CW'(1) :
              (COL_INC[slot_idx] ? col_q + CW'(1) : col_q);
  assign slot_ok = !(ROW_DEC[slot_idx] && (row_q == '0)) &&
                   !(ROW_INC[slot_idx] && (row_q == LAST_IDX)) &&
                   !(COL_DEC[slot_idx] && (col_q == '0)) &&
                   !(COL_INC[slot_idx] && (col_q == LAST_IDX));

  // Returning neighbour word: votes only if in the grid and a legal state
  assign cap_idx     = 3'(slot_q - 4'd1);
  assign cap_val.st  = mem_rdata_q;
  assign cap_val.vld = issue_ok_q && (mem_rdata_q != '0) && (mem_rdata_q <= MAX_ST);

  // Sequencer: next state, RAM port and result words
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    row_d       = row_q;
    col_d       = col_q;
    sv_d        = sv_q;
    resp_st_d   = resp_st_q;
    resp_n_d    = resp_n_q;
    slot_d      = slot_q;
    issue_ok_d  = issue_ok_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_st_d    = out_st_q;
    out_n_d     = out_n_q;
    in_ready_o  = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = {row_q, col_q};
    mem_wdata   = sv_clamp;
    cap_we      = 1'b0;
    vote_start  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d = cmd_i;
          row_d = row_x[CW-1:0];
          col_d = col_x[CW-1:0];
          sv_d  = state_value_i;
          if (in_grid) begin
            state_d = ST_EXEC;
          end else begin
            resp_st_d = '0;
            resp_n_d  = '0;
            state_d   = ST_RESP;
          end
        end
      end
      ST_EXEC: begin
        resp_n_d = '0;
        if (cmd_q == CMD_WRITE) begin
          mem_we    = 1'b1;
          resp_st_d = sv_clamp;
          state_d   = ST_RESP;
        end else if (cmd_q == CMD_UPDATE) begin
          slot_d  = '0;
          state_d = ST_NBR;
        end else begin
          state_d = ST_RDWAIT;
        end
      end
      ST_RDWAIT: begin
        resp_st_d = mem_rdata_q;
        state_d   = ST_RESP;
      end
      ST_NBR: begin
        // issue slot k while capturing the word of slot k-1; the vote starts
        // once the last neighbour word has landed in nbr_q
        if (!slot_q[3]) begin
          mem_addr   = {nr, nc};
          issue_ok_d = slot_ok;
        end
        if ((slot_q != '0) && (slot_q <= 4'd8)) begin
          cap_we = 1'b1;
        end
        if (slot_q == 4'd9) begin
          vote_start = 1'b1;
          state_d    = ST_VOTE;
        end else begin
          slot_d = slot_q + 4'd1;
        end
      end
      ST_VOTE: begin
        if (vote_res.done) begin
          mem_we    = 1'b1;
          mem_wdata = vote_res.best_st;
          resp_st_d = vote_res.best_st;
          resp_n_d  = vote_res.best_n;
          state_d   = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_st_d    = resp_st_q;
          out_n_d     = resp_n_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      issue_ok_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      issue_ok_q  <= issue_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    row_q     <= row_d;
    col_q     <= col_d;
    sv_q      <= sv_d;
    resp_st_q <= resp_st_d;
    resp_n_q  <= resp_n_d;
    out_st_q  <= out_st_d;
    out_n_q   <= out_n_d;
    if (cap_we) begin
      nbr_q[cap_idx] <= cap_val;
    end
  end

  // Grid RAM: single port, read-first, registered read data
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_q <= grid_mem[mem_addr];
  end

  nmu_vote u_vote (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (vote_start),
    .nbr_i   (nbr_q),
    .res_o   (vote_res)
  );

  assign out_valid_o    = out_valid_q;
  assign cell_state_o   = out_st_q;
  assign winner_votes_o = out_n_q;

endmodule : neighbor_majority_update_core
`default_nettype wire

FILE: sv/nmu_checker.sv
// nmu_port_checks: port-level checks for neighbor_majority_update_core, bound in below.
// Depends on nmu_pkg.
`default_nettype none
module nmu_port_checks
  import nmu_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic [1:0]         cmd_i,
  input wire logic [COORD_W-1:0] row_i,
  input wire logic [COORD_W-1:0] col_i,
  input wire logic [STATE_W-1:0] state_value_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [STATE_W-1:0] cell_state_o,
  input wire logic [VOTE_W-1:0]  winner_votes_o
);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_o;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cell_state_o) &&
    $stable(winner_votes_o))
    else $error("result word changed while stalled");

  // One word at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("input accepted while a word is in work");

  // No result can appear in the cycle after acceptance
  a_min_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !$rose(out_valid_o))
    else $error("result appeared too early");

  // Votes never exceed the neighbourhood, and any vote names a real state
  a_votes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (winner_votes_o != '0) |->
    (winner_votes_o <= VOTE_W'(NUM_NBR)) && (cell_state_o != '0))
    else $error("bad vote count or state in result");

endmodule : nmu_port_checks

bind neighbor_majority_update_core nmu_port_checks u_nmu_port_checks (.*);
`default_nettype wire

FILE: dv/nmu_checker.sv
`timescale 1ns / 100ps
// nmu_checker: watches both channels of neighbor_majority_update_core, predicts
// each result word from a private copy of the grid and compares in order.
// Depends on nmu_pkg.
module nmu_checker
  import nmu_pkg::*;
#(
  parameter int unsigned GRID_SIDE  = 256,
  parameter int unsigned NUM_STATES = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         cmd_i,
  input  logic [COORD_W-1:0] row_i,
  input  logic [COORD_W-1:0] col_i,
  input  logic [STATE_W-1:0] state_value_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [STATE_W-1:0] cell_state_i,
  input  logic [VOTE_W-1:0]  winner_votes_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);

  typedef struct packed {
    logic [STATE_W-1:0] cell_state;
    logic [VOTE_W-1:0]  winner_votes;
  } cell_result_t;

  // Private grid copy; entries are only looked at once written
  bit [STATE_W-1:0] grid_copy [GRID_SIDE*GRID_SIDE];
  cell_result_t     results_due [$];
  cell_result_t     want;
  int unsigned      mismatches = 0;

  assign fail_count_o = mismatches;

  initial pending_o = 0;

  // Applies one command word to the grid copy and returns the result word
  function automatic cell_result_t apply_command(logic [1:0] cmd, logic [COORD_W-1:0] row,
                                                 logic [COORD_W-1:0] col,
                                                 logic [STATE_W-1:0] sv);
    int unsigned      tally [0:31];
    int unsigned      idx, best_n;
    int               dr, dc, nr, nc, s;
    logic [STATE_W-1:0] best, st;
    cell_result_t     res;
    res = '0;
    if (row >= GRID_SIDE || col >= GRID_SIDE) return res;
    idx = row * GRID_SIDE + col;
    case (cmd)
      CMD_WRITE: begin
        if (sv == '0) grid_copy[idx] = STATE_W'(1);
        else if (sv > NUM_STATES) grid_copy[idx] = STATE_W'(NUM_STATES);
        else grid_copy[idx] = sv;
      end
      CMD_UPDATE: begin
        foreach (tally[i]) tally[i] = 0;
        // histogram of the in-grid Moore neighbours, no wraparound
        for (dr = -1; dr <= 1; dr++) begin
          for (dc = -1; dc <= 1; dc++) begin
            nr = int'(row) + dr;
            nc = int'(col) + dc;
            if (dr == 0 && dc == 0) continue;
            if (nr < 0 || nc < 0 || nr >= int'(GRID_SIDE) || nc >= int'(GRID_SIDE)) continue;
            st = grid_copy[nr * GRID_SIDE + nc];
            if (st >= 1 && st <= NUM_STATES) tally[st]++;
          end
        end
        // strict greater-than keeps the lowest state on a tie
        best   = STATE_W'(1);
        best_n = 0;
        for (s = 1; s <= int'(NUM_STATES); s++) begin
          if (tally[s] > best_n) begin
            best_n = tally[s];
            best   = s[STATE_W-1:0];
          end
        end
        grid_copy[idx]   = best;
        res.winner_votes = best_n[VOTE_W-1:0];
      end
      default: ;  // read, and the spare code which reads too
    endcase
    res.cell_state = grid_copy[idx];
    return res;
  endfunction

  // Compare the result word, then predict from the accepted command word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          $error("result word with nothing outstanding: cell_state %0d winner_votes %0d",
                 cell_state_i, winner_votes_i);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (cell_state_i !== want.cell_state) begin
            $error("cell_state: expected %0d, actual %0d", want.cell_state, cell_state_i);
            mismatches++;
          end
          if (winner_votes_i !== want.winner_votes) begin
            $error("winner_votes: expected %0d, actual %0d", want.winner_votes,
                   winner_votes_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        results_due.push_back(apply_command(cmd_i, row_i, col_i, state_value_i));
      pending_o <= results_due.size();
    end
  end

endmodule

FILE: dv/neighbor_majority_update_core_tb.sv
`timescale 1ns / 100ps
// neighbor_majority_update_core_tb: drives command words into the core, stalls
// both channels at random and gives the verdict. Depends on nmu_pkg, the core
// and nmu_checker.
module neighbor_majority_update_core_tb;
  import nmu_pkg::*;

  localparam int unsigned GRID_SIDE      = 256;
  localparam int unsigned NUM_STATES     = 20;
  localparam int unsigned REGION         = 6;       // side of the working patch
  localparam int unsigned RANDOM_WORDS   = 1100;
  localparam int unsigned TIMEOUT_CYCLES = 400000;
  localparam logic [1:0]  CMD_SPARE      = 2'd3;    // unused code, reads

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         cmd_i;
  logic [COORD_W-1:0] row_i;
  logic [COORD_W-1:0] col_i;
  logic [STATE_W-1:0] state_value_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [STATE_W-1:0] cell_state_o;
  logic [VOTE_W-1:0]  winner_votes_o;

  int unsigned cycle_cnt = 0;
  int unsigned fail_cnt;
  int unsigned results_pending;
  int unsigned n_write = 0, n_update = 0, n_read = 0, n_spare = 0;
  bit          tx_calm = 1'b0;
  // cells that hold a written state, so no word ever reads an unwritten one
  bit          cell_loaded [GRID_SIDE*GRID_SIDE];

  neighbor_majority_update_core #(
    .GRID_SIDE  (GRID_SIDE),
    .NUM_STATES (NUM_STATES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .state_value_i  (state_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cell_state_o   (cell_state_o),
    .winner_votes_o (winner_votes_o)
  );

  nmu_checker #(
    .GRID_SIDE  (GRID_SIDE),
    .NUM_STATES (NUM_STATES)
  ) u_nmu_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .cmd_i          (cmd_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .state_value_i  (state_value_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cell_state_i   (cell_state_o),
    .winner_votes_i (winner_votes_o),
    .fail_count_o   (fail_cnt),
    .pending_o      (results_pending)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: stalls about one cycle in six, never inside a quiet window
  always @(posedge clk_i)
    out_ready_i <= (cycle_cnt >= 6000 && cycle_cnt < 12000) || ($urandom_range(0, 99) >= 16);

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= TIMEOUT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Present one word, with random idle cycles ahead of it, and hold to acceptance
  task automatic send_word(input logic [1:0] cmd, input int unsigned row,
                           input int unsigned col, input logic [STATE_W-1:0] sv);
    while (!tx_calm && $urandom_range(0, 99) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    row_i         <= row[COORD_W-1:0];
    col_i         <= col[COORD_W-1:0];
    state_value_i <= sv;
    case (cmd)
      CMD_WRITE:  n_write++;
      CMD_UPDATE: n_update++;
      CMD_READ:   n_read++;
      default:    n_spare++;
    endcase
    if (cmd == CMD_WRITE || cmd == CMD_UPDATE) cell_loaded[row * GRID_SIDE + col] = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Hold the sender off until every result word is back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned        k, roll, base_r, base_c, pal_n, mr, mc;
    int                 r, c, dr, dc, nr, nc;
    bit                 wide, miss;
    logic [STATE_W-1:0] palette [4];

    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    cmd_i         <= CMD_READ;
    row_i         <= '0;
    col_i         <= '0;
    state_value_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Top-left corner: zero clamps to 1, 31 clamps to the top state
    send_word(CMD_WRITE, 0, 0, 5'd0);
    send_word(CMD_WRITE, 0, 1, 5'd31);
    send_word(CMD_WRITE, 1, 0, 5'd20);
    send_word(CMD_WRITE, 1, 1, 5'd20);
    send_word(CMD_UPDATE, 0, 0, 5'd0);
    send_word(CMD_READ, 0, 0, 5'd31);
    // Bottom-right corner: three-way tie goes to the lowest state
    send_word(CMD_WRITE, 255, 255, 5'd5);
    send_word(CMD_WRITE, 254, 255, 5'd3);
    send_word(CMD_WRITE, 255, 254, 5'd5);
    send_word(CMD_WRITE, 254, 254, 5'd7);
    send_word(CMD_UPDATE, 255, 255, 5'd31);
    send_word(CMD_SPARE, 255, 255, 5'd0);
    // Interior cell, all eight neighbours agree
    for (dr = -1; dr <= 1; dr++)
      for (dc = -1; dc <= 1; dc++)
        if (dr != 0 || dc != 0) send_word(CMD_WRITE, 128 + dr, 128 + dc, 5'd21);
    send_word(CMD_UPDATE, 128, 128, 5'd10);
    send_word(CMD_READ, 128, 128, 5'd31);
    drain();

    // Random part: work a small patch with a few states so majorities and ties show up
    for (k = 0; k < RANDOM_WORDS; k++) begin
      if (k % 50 == 0) begin
        case ($urandom_range(0, 4))
          0:       base_r = 0;
          1:       base_r = GRID_SIDE - REGION;
          default: base_r = $urandom_range(0, GRID_SIDE - REGION);
        endcase
        case ($urandom_range(0, 4))
          0:       base_c = 0;
          1:       base_c = GRID_SIDE - REGION;
          default: base_c = $urandom_range(0, GRID_SIDE - REGION);
        endcase
        wide  = ($urandom_range(0, 4) == 0);
        pal_n = $urandom_range(1, 4);
        foreach (palette[i])
          palette[i] = wide ? STATE_W'($urandom_range(0, 31)) :
                              STATE_W'($urandom_range(1, NUM_STATES));
      end
      tx_calm = (k >= 450 && k < 700);
      if (k == 550) drain();
      roll = $urandom_range(0, 99);
      r    = base_r + $urandom_range(0, REGION - 1);
      c    = base_c + $urandom_range(0, REGION - 1);
      if (roll < 5) begin
        // stray write anywhere in the grid
        send_word(CMD_WRITE, $urandom_range(0, GRID_SIDE - 1),
                  $urandom_range(0, GRID_SIDE - 1), STATE_W'($urandom_range(0, 31)));
      end else if (roll < 35) begin
        send_word(CMD_WRITE, r, c, palette[$urandom_range(0, pal_n - 1)]);
      end else if (roll < 75) begin
        // an update needs its whole neighbourhood loaded; else fill a gap first
        miss = 1'b0;
        for (dr = -1; dr <= 1; dr++) begin
          for (dc = -1; dc <= 1; dc++) begin
            nr = r + dr;
            nc = c + dc;
            if ((dr != 0 || dc != 0) && !miss && nr >= 0 && nc >= 0 &&
                nr < int'(GRID_SIDE) && nc < int'(GRID_SIDE) &&
                !cell_loaded[nr * GRID_SIDE + nc]) begin
              miss = 1'b1;
              mr   = nr;
              mc   = nc;
            end
          end
        end
        if (miss) send_word(CMD_WRITE, mr, mc, palette[$urandom_range(0, pal_n - 1)]);
        else send_word(CMD_UPDATE, r, c, STATE_W'($urandom_range(0, 31)));
      end else if (!cell_loaded[r * GRID_SIDE + c]) begin
        send_word(CMD_WRITE, r, c, palette[$urandom_range(0, pal_n - 1)]);
      end else if (roll < 95) begin
        send_word(CMD_READ, r, c, STATE_W'($urandom_range(0, 31)));
      end else begin
        send_word(CMD_SPARE, r, c, STATE_W'($urandom_range(0, 31)));
      end
    end

    drain();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d writes, %0d majority updates, %0d reads, %0d spare-code reads",
             n_write, n_update, n_read, n_spare);
    $display("over corners, edges and interior patches in %0d cycles with random stalls",
             cycle_cnt);
    if (fail_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
